// ----- design/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the static linked list engine
// Slot geometry, command and status codes, controller states and the
// status flags that the datapath returns to the controller.
// ----------------------------------------------------------------------------
package sle_pkg;

  // Slot array geometry
  localparam int SLOTS  = 128;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W  = ((ADDR_W > 7) ? ADDR_W : 7) + 1;
  localparam logic [ADDR_W-1:0] LIST_HEAD = ADDR_W'(SLOTS - 1);
  localparam logic [ADDR_W-1:0] FREE_HEAD = '0;

  // Field widths of one beat
  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 8;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 7;
  localparam int LEN_W  = 7;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_PRIOR  = 3'd4,
    CMD_NEXT   = 3'd5,
    CMD_TOGGLE = 3'd6,
    CMD_CLEAR  = 3'd7
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_POS  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Controller states; the state is also the command to the datapath
  typedef enum logic [36:0] {
    S_INIT     = 37'd1 << 0,
    S_IDLE     = 37'd1 << 1,
    S_DISPATCH = 37'd1 << 2,
    S_WALK     = 37'd1 << 3,
    S_WALK_W   = 37'd1 << 4,
    S_GET0     = 37'd1 << 5,
    S_GET1     = 37'd1 << 6,
    S_INS0     = 37'd1 << 7,
    S_INS1     = 37'd1 << 8,
    S_INS2     = 37'd1 << 9,
    S_INS3     = 37'd1 << 10,
    S_INS4     = 37'd1 << 11,
    S_INS5     = 37'd1 << 12,
    S_INS6     = 37'd1 << 13,
    S_UNL0     = 37'd1 << 14,
    S_UNL1     = 37'd1 << 15,
    S_UNL2     = 37'd1 << 16,
    S_UNL3     = 37'd1 << 17,
    S_UNL4     = 37'd1 << 18,
    S_UNL5     = 37'd1 << 19,
    S_UNL6     = 37'd1 << 20,
    S_UNL7     = 37'd1 << 21,
    S_F0       = 37'd1 << 22,
    S_F1       = 37'd1 << 23,
    S_FS       = 37'd1 << 24,
    S_FW       = 37'd1 << 25,
    S_NX0      = 37'd1 << 26,
    S_NX1      = 37'd1 << 27,
    S_C0       = 37'd1 << 28,
    S_C1       = 37'd1 << 29,
    S_C2       = 37'd1 << 30,
    S_C3       = 37'd1 << 31,
    S_C4       = 37'd1 << 32,
    S_C5       = 37'd1 << 33,
    S_C6       = 37'd1 << 34,
    S_C7       = 37'd1 << 35,
    S_FIN      = 37'd1 << 36
  } state_e;

  // Status from datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic pos_bad;
    logic k_zero;
    logic lr_zero;
    logic scan_end;
    logic match;
    logic more;
    logic init_last;
    logic out_free;
  } dp_flags_t;

endpackage

// ----- design/sle_ram.sv -----
// ----------------------------------------------------------------------------
// sle_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sle_datapath.sv -----
// ----------------------------------------------------------------------------
// sle_datapath: slot memories, walk registers and result register
// Executes the step named by the controller state and reports flags back.
// ----------------------------------------------------------------------------
module sle_datapath import sle_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  state_e           op_i,
  output dp_flags_t        flags_o,
  input  logic             s_axis_tvalid,
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata
);

  // Command registers
  cmd_e              cmd_q;
  logic [POS_W-1:0]  pos_q;
  logic [VAL_W-1:0]  val_q;
  // Walk registers
  logic [ADDR_W-1:0] cur_q, prev_q, tmp_q, nxt_q;
  logic [CNT_W-1:0]  k_q, n_q;
  logic [ADDR_W-1:0] len_q;
  logic [VAL_W-1:0]  pdat_q;
  // Result being built
  status_e           status_q;
  logic [VAL_W-1:0]  rv_q;
  logic [ADDR_W-1:0] slot_q;
  // Output register
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  // Memory ports
  logic [ADDR_W-1:0] raddr;
  logic              link_we;
  logic [ADDR_W-1:0] link_waddr, link_wdata, lr;
  logic              elem_we;
  logic [VAL_W-1:0]  er;

  logic [CNT_W-1:0]  pos_x, len_x;
  logic              out_free;
  logic              match;
  logic [ADDR_W+6:0] len_ext, slot_ext;

  sle_ram #(.WIDTH(ADDR_W), .DEPTH(SLOTS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (raddr),
    .rdata_o (lr)
  );

  sle_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (tmp_q),
    .wdata_i (val_q),
    .raddr_i (raddr),
    .rdata_o (er)
  );

  assign pos_x    = CNT_W'(pos_q);
  assign len_x    = CNT_W'(len_q);
  assign out_free = !out_valid_q || m_axis_tready;
  assign match    = (er == val_q) && !((cmd_q == CMD_PRIOR) && (n_q == '0));

  // Flags for the controller
  always_comb begin
    flags_o.cmd       = cmd_q;
    case (cmd_q)
      CMD_INSERT:         flags_o.pos_bad = (pos_q == '0) || (pos_x > len_x + 1'b1);
      CMD_DELETE, CMD_GET: flags_o.pos_bad = (pos_q == '0) || (pos_x > len_x);
      default:            flags_o.pos_bad = 1'b0;
    endcase
    flags_o.k_zero    = (k_q == '0);
    flags_o.lr_zero   = (lr == '0);
    flags_o.scan_end  = (cur_q == '0) || (n_q >= len_x);
    flags_o.match     = match;
    flags_o.more      = (lr != '0) && (n_q < len_x);
    flags_o.init_last = (k_q == CNT_W'(SLOTS - 1));
    flags_o.out_free  = out_free;
  end

  // Read address select
  always_comb begin
    case (op_i)
      S_WALK, S_GET0, S_F0, S_FS, S_C2: raddr = cur_q;
      S_INS2, S_UNL2:                   raddr = tmp_q;
      S_INS4, S_UNL0:                   raddr = prev_q;
      S_NX0:                            raddr = nxt_q;
      S_C0:                             raddr = LIST_HEAD;
      default:                          raddr = FREE_HEAD;
    endcase
  end

  // Link write select
  always_comb begin
    link_we    = 1'b1;
    link_waddr = FREE_HEAD;
    link_wdata = '0;
    elem_we    = (op_i == S_INS3);
    case (op_i)
      S_INIT: begin
        link_waddr = k_q[ADDR_W-1:0];
        link_wdata = (k_q < CNT_W'(SLOTS - 2)) ? ADDR_W'(k_q + 1'b1) : '0;
      end
      S_INS3: link_wdata = lr;
      S_INS5: begin
        link_waddr = tmp_q;
        link_wdata = lr;
      end
      S_INS6: begin
        link_waddr = prev_q;
        link_wdata = tmp_q;
      end
      S_UNL5: begin
        link_waddr = prev_q;
        link_wdata = nxt_q;
      end
      S_UNL6: begin
        link_waddr = tmp_q;
        link_wdata = cur_q;
      end
      S_UNL7, S_C6: link_wdata = tmp_q;
      S_C5: begin
        link_waddr = cur_q;
        link_wdata = lr;
      end
      S_C7:    link_waddr = LIST_HEAD;
      default: link_we = 1'b0;
    endcase
  end

  // Control registers: init counter, length, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (op_i)
        S_INIT: k_q <= k_q + 1'b1;
        S_DISPATCH: begin
          if ((cmd_q == CMD_INSERT) || (cmd_q == CMD_DELETE)) begin
            k_q <= pos_x - 1'b1;
          end else begin
            k_q <= pos_x;
          end
        end
        S_WALK_W: k_q <= k_q - 1'b1;
        S_INS6:   len_q <= len_q + 1'b1;
        S_UNL7:   len_q <= len_q - 1'b1;
        S_C7:     len_q <= '0;
        default: ;
      endcase
      if (op_i == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign len_ext  = {{7{1'b0}}, len_q};
  assign slot_ext = {{7{1'b0}}, slot_q};

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_q <= cmd_e'(s_axis_tdata[CMD_W-1:0]);
          pos_q <= s_axis_tdata[CMD_W +: POS_W];
          val_q <= s_axis_tdata[CMD_W+POS_W +: VAL_W];
        end
      end
      S_DISPATCH: begin
        status_q <= flags_o.pos_bad ? ST_BAD_POS : ST_OK;
        rv_q     <= '0;
        slot_q   <= '0;
        cur_q    <= LIST_HEAD;
        prev_q   <= LIST_HEAD;
        n_q      <= '0;
      end
      S_WALK: begin
        if (k_q == '0) begin
          prev_q <= cur_q;
        end
      end
      S_WALK_W, S_F1: cur_q <= lr;
      S_GET1, S_NX1:  rv_q <= er;
      S_INS1: begin
        tmp_q <= lr;
        if (lr == '0) begin
          status_q <= ST_FULL;
        end
      end
      S_INS6: begin
        if (cmd_q == CMD_TOGGLE) begin
          rv_q <= val_q;
        end
      end
      S_UNL1: tmp_q <= lr;
      S_UNL3: begin
        nxt_q <= lr;
        rv_q  <= er;
      end
      S_UNL5: cur_q <= lr;
      S_FS: begin
        if (flags_o.scan_end) begin
          prev_q <= LIST_HEAD;
          if (cmd_q != CMD_TOGGLE) begin
            status_q <= ST_NOTFOUND;
          end
        end
      end
      S_FW: begin
        if (match) begin
          nxt_q <= lr;
          if (cmd_q == CMD_LOCATE) begin
            slot_q <= cur_q;
          end
          if (cmd_q == CMD_PRIOR) begin
            rv_q <= pdat_q;
          end
          if ((cmd_q == CMD_NEXT) && (lr == '0)) begin
            status_q <= ST_NOTFOUND;
          end
        end else begin
          prev_q <= cur_q;
          pdat_q <= er;
          cur_q  <= lr;
          n_q    <= n_q + 1'b1;
        end
      end
      S_C1: begin
        tmp_q <= lr;
        cur_q <= lr;
        n_q   <= CNT_W'(1);
      end
      S_C3: begin
        if (flags_o.more) begin
          cur_q <= lr;
          n_q   <= n_q + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_data_q <= {len_ext[LEN_W-1:0], slot_ext[SLOT_W-1:0], rv_q, status_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- design/sle_ctrl.sv -----
// ----------------------------------------------------------------------------
// sle_ctrl: command sequencer of the static linked list engine
// One-hot state machine that steps each command through memory reads,
// link updates and result delivery.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_flags_t flags_i,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  output state_e    op_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:     if (flags_i.init_last) state_d = S_IDLE;
      S_IDLE:     if (s_axis_tvalid) state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (flags_i.pos_bad) begin
          state_d = S_FIN;
        end else begin
          case (flags_i.cmd)
            CMD_INSERT, CMD_DELETE, CMD_GET: state_d = S_WALK;
            CMD_CLEAR:                       state_d = S_C0;
            default:                         state_d = S_F0;
          endcase
        end
      end
      S_WALK: begin
        if (!flags_i.k_zero) begin
          state_d = S_WALK_W;
        end else begin
          case (flags_i.cmd)
            CMD_INSERT: state_d = S_INS0;
            CMD_DELETE: state_d = S_UNL0;
            default:    state_d = S_GET0;
          endcase
        end
      end
      S_WALK_W: state_d = S_WALK;
      S_GET0:   state_d = S_GET1;
      S_GET1:   state_d = S_FIN;
      S_INS0:   state_d = S_INS1;
      S_INS1:   state_d = flags_i.lr_zero ? S_FIN : S_INS2;
      S_INS2:   state_d = S_INS3;
      S_INS3:   state_d = S_INS4;
      S_INS4:   state_d = S_INS5;
      S_INS5:   state_d = S_INS6;
      S_INS6:   state_d = S_FIN;
      S_UNL0:   state_d = S_UNL1;
      S_UNL1:   state_d = S_UNL2;
      S_UNL2:   state_d = S_UNL3;
      S_UNL3:   state_d = S_UNL4;
      S_UNL4:   state_d = S_UNL5;
      S_UNL5:   state_d = S_UNL6;
      S_UNL6:   state_d = S_UNL7;
      S_UNL7:   state_d = S_FIN;
      S_F0:     state_d = S_F1;
      S_F1:     state_d = S_FS;
      S_FS: begin
        if (!flags_i.scan_end) begin
          state_d = S_FW;
        end else if (flags_i.cmd == CMD_TOGGLE) begin
          state_d = S_INS0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FW: begin
        if (!flags_i.match) begin
          state_d = S_FS;
        end else begin
          case (flags_i.cmd)
            CMD_NEXT:   state_d = flags_i.lr_zero ? S_FIN : S_NX0;
            CMD_TOGGLE: state_d = S_UNL0;
            default:    state_d = S_FIN;
          endcase
        end
      end
      S_NX0:    state_d = S_NX1;
      S_NX1:    state_d = S_FIN;
      S_C0:     state_d = S_C1;
      S_C1:     state_d = flags_i.lr_zero ? S_FIN : S_C2;
      S_C2:     state_d = S_C3;
      S_C3:     state_d = flags_i.more ? S_C2 : S_C4;
      S_C4:     state_d = S_C5;
      S_C5:     state_d = S_C6;
      S_C6:     state_d = S_C7;
      S_C7:     state_d = S_FIN;
      S_FIN:    if (flags_i.out_free) state_d = S_IDLE;
      default:  state_d = S_INIT;
    endcase
  end

  // State register; reset starts the link clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign op_o          = state_q;

endmodule

// ----- design/static_linked_list_engine.sv -----
// ----------------------------------------------------------------------------
// static_linked_list_engine: cursor-linked byte list with a free chain
// Top level joining the command sequencer and the slot datapath.
// ----------------------------------------------------------------------------
// After reset the block writes the link of every slot to build the free
// chain and accepts no command until then. Commands run one at a time. Each
// step along a chain passes through a read state and a wait state, since
// the slot memories have a registered read. Next fetches the neighbor after
// its scan, toggle runs an insert or a delete sequence after its scan, and a
// bad position is answered straight from dispatch. A new command is taken
// while the previous result still waits in the output register.
module static_linked_list_engine import sle_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd[2:0], position[9:3], value[17:10], zero[23:18]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status[1:0], result_value[9:2], slot[16:10], length[23:17]
  output logic [OUT_W-1:0] m_axis_tdata
);

  state_e    op;
  dp_flags_t flags;

  sle_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .flags_i       (flags),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .op_o          (op)
  );

  sle_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .flags_o       (flags),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- dv/static_linked_list_checker.sv -----
// ----------------------------------------------------------------------------
// static_linked_list_checker: list command predictor and result comparator
// Watches both stream channels, keeps its own copy of the slot array, works
// out the response to every accepted command and compares each returned beat
// field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module static_linked_list_checker import sle_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [OUT_W-1:0] m_axis_tdata,
  output int               fail_count_o,
  output int               pending_o,
  output logic             beat_o
);

  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  rvalue;
    status_e           status;
  } reply_t;

  logic [ADDR_W-1:0] nxt_q [SLOTS];
  logic [VAL_W-1:0]  byte_q [SLOTS];
  int                len_q;
  reply_t            replies_q [$];

  function automatic logic [ADDR_W-1:0] walk_to(int k);
    logic [ADDR_W-1:0] s;
    s = LIST_HEAD;
    for (int i = 0; i < k; i++) s = nxt_q[s];
    return s;
  endfunction

  // first slot holding v (0 if none) and its predecessor
  function automatic logic [ADDR_W-1:0] find_val(logic [VAL_W-1:0] v,
                                                 output logic [ADDR_W-1:0] pred);
    logic [ADDR_W-1:0] p, s;
    p = LIST_HEAD;
    s = nxt_q[LIST_HEAD];
    pred = LIST_HEAD;
    for (int n = 0; s != 0 && n < len_q; n++) begin
      if (byte_q[s] == v) begin
        pred = p;
        return s;
      end
      p = s;
      s = nxt_q[s];
    end
    pred = LIST_HEAD;
    return '0;
  endfunction

  function automatic status_e put_after(logic [ADDR_W-1:0] prev, logic [VAL_W-1:0] v);
    logic [ADDR_W-1:0] j;
    j = nxt_q[FREE_HEAD];
    if (j == 0) return ST_FULL;
    nxt_q[FREE_HEAD] = nxt_q[j];
    byte_q[j] = v;
    nxt_q[j] = nxt_q[prev];
    nxt_q[prev] = j;
    len_q++;
    return ST_OK;
  endfunction

  function automatic logic [VAL_W-1:0] take_after(logic [ADDR_W-1:0] prev);
    logic [ADDR_W-1:0] j;
    j = nxt_q[prev];
    nxt_q[prev] = nxt_q[j];
    nxt_q[j] = nxt_q[FREE_HEAD];
    nxt_q[FREE_HEAD] = j;
    if (len_q > 0) len_q--;
    return byte_q[j];
  endfunction

  function automatic reply_t run_command(cmd_e cmd, int pos, logic [VAL_W-1:0] v);
    reply_t r;
    logic [ADDR_W-1:0] s, p, first, tail;
    int n;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (pos < 1 || pos > len_q + 1) r.status = ST_BAD_POS;
        else r.status = put_after(walk_to(pos - 1), v);
      end
      CMD_DELETE, CMD_GET: begin
        if (pos < 1 || pos > len_q) r.status = ST_BAD_POS;
        else if (cmd == CMD_DELETE) r.rvalue = take_after(walk_to(pos - 1));
        else r.rvalue = byte_q[walk_to(pos)];
      end
      CMD_LOCATE: begin
        r.slot = find_val(v, p);
        if (r.slot == 0) r.status = ST_NOTFOUND;
      end
      CMD_PRIOR: begin
        if (len_q < 2) r.status = ST_NOTFOUND;
        else begin
          n = 1;
          p = nxt_q[LIST_HEAD];
          s = nxt_q[p];
          while (s != 0 && n < len_q && byte_q[s] != v) begin
            p = s;
            s = nxt_q[s];
            n++;
          end
          if (s != 0 && n < len_q) r.rvalue = byte_q[p];
          else r.status = ST_NOTFOUND;
        end
      end
      CMD_NEXT: begin
        s = find_val(v, p);
        if (s != 0 && nxt_q[s] != 0) r.rvalue = byte_q[nxt_q[s]];
        else r.status = ST_NOTFOUND;
      end
      CMD_TOGGLE: begin
        s = find_val(v, p);
        if (s != 0) r.rvalue = take_after(p);
        else begin
          r.status = put_after(LIST_HEAD, v);
          if (r.status == ST_OK) r.rvalue = v;
        end
      end
      default: begin
        first = nxt_q[LIST_HEAD];
        if (first != 0) begin
          tail = first;
          n = 1;
          while (nxt_q[tail] != 0 && n < len_q) begin
            tail = nxt_q[tail];
            n++;
          end
          nxt_q[tail] = nxt_q[FREE_HEAD];
          nxt_q[FREE_HEAD] = first;
          nxt_q[LIST_HEAD] = '0;
          len_q = 0;
        end
      end
    endcase
    r.length = LEN_W'(len_q);
    return r;
  endfunction

  assign pending_o = replies_q.size();
  assign beat_o = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready);

  // Predict on command beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) nxt_q[i] = (i < SLOTS - 2) ? ADDR_W'(i + 1) : '0;
      len_q = 0;
      replies_q.delete();
      fail_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = reply_t'(m_axis_tdata);
        if (replies_q.size() == 0) begin
          $error("unexpected result beat %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = replies_q.pop_front();
          if (got.status !== want.status)
            $error("status: expected %0d, actual %0d", want.status, got.status);
          if (got.rvalue !== want.rvalue)
            $error("result_value: expected %0d, actual %0d", want.rvalue, got.rvalue);
          if (got.slot !== want.slot)
            $error("slot: expected %0d, actual %0d", want.slot, got.slot);
          if (got.length !== want.length)
            $error("length: expected %0d, actual %0d", want.length, got.length);
          if (got !== want) fail_count_o <= fail_count_o + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        replies_q.push_back(run_command(cmd_e'(s_axis_tdata[2:0]),
                                        int'(s_axis_tdata[9:3]), s_axis_tdata[17:10]));
    end
  end

endmodule

// ----- dv/static_linked_list_engine_tb.sv -----
// ----------------------------------------------------------------------------
// static_linked_list_engine_tb: stimulus and verdict for the list engine
// Drives directed corner commands, fills the list past full, then a random
// command mix that also drains and clears it, with random gaps on commands and
// back-pressure on results; the checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module static_linked_list_engine_tb;
  import sle_pkg::*;

  localparam int WDOG_LIMIT = 20000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  int               fail_count;
  int               pending;
  logic             beat;
  int               idle_cycles = 0;
  int               list_len = 0;
  bit               hold_off = 1'b0;
  bit               rx_beat = 1'b0;
  int               rx_wait = 0;

  always #6 clk_i = ~clk_i;

  static_linked_list_engine uut (.*);

  static_linked_list_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .beat_o(beat)
  );

  // Send one command beat after a random gap
  task automatic send_cmd(cmd_e cmd, int pos, int v);
    int gap;
    gap = $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {6'b0, 8'(v), 7'(pos), cmd};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    // rough length track to steer the mix
    if (cmd == CMD_INSERT && pos >= 1 && pos <= list_len + 1 && list_len < 126) list_len++;
    if (cmd == CMD_DELETE && pos >= 1 && pos <= list_len) list_len--;
    if (cmd == CMD_CLEAR) list_len = 0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Note each result beat so the receiver draws a new wait
  always @(posedge clk_i) begin
    rx_beat <= m_axis_tvalid && m_axis_tready;
  end

  // Receiver: random wait before each beat, plus one long hold-off
  always @(negedge clk_i) begin
    if (rx_beat) rx_wait = $urandom_range(0, 11);
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (rx_wait != 0) begin
      m_axis_tready <= 1'b0;
      rx_wait = rx_wait - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (beat || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int c, r, v;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners on an empty and a short list
    send_cmd(CMD_PRIOR, 0, 5);
    send_cmd(CMD_CLEAR, 0, 0);
    send_cmd(CMD_GET, 1, 0);
    send_cmd(CMD_DELETE, 0, 0);
    send_cmd(CMD_INSERT, 0, 1);
    send_cmd(CMD_INSERT, 2, 1);
    send_cmd(CMD_INSERT, 1, 8'hff);
    send_cmd(CMD_PRIOR, 0, 8'hff);
    send_cmd(CMD_INSERT, 2, 8'h00);
    send_cmd(CMD_INSERT, 1, 8'hAA);
    send_cmd(CMD_LOCATE, 0, 8'h00);
    send_cmd(CMD_LOCATE, 127, 8'h55);
    send_cmd(CMD_PRIOR, 0, 8'h00);
    send_cmd(CMD_PRIOR, 0, 8'hAA);
    send_cmd(CMD_NEXT, 0, 8'hAA);
    send_cmd(CMD_NEXT, 0, 8'h00);
    send_cmd(CMD_GET, 3, 0);
    send_cmd(CMD_GET, 4, 0);
    send_cmd(CMD_DELETE, 3, 0);
    send_cmd(CMD_TOGGLE, 0, 8'hAA);
    send_cmd(CMD_TOGGLE, 0, 8'h55);
    send_cmd(CMD_CLEAR, 127, 8'hff);

    // Fill to full, overflow, then one long receiver hold-off
    for (int i = 0; i < 128; i++) send_cmd(CMD_INSERT, 1, $urandom_range(0, 255));
    send_cmd(CMD_TOGGLE, 0, 300 & 8'hff);
    send_cmd(CMD_GET, 126, 0);
    send_cmd(CMD_DELETE, 126, 0);
    send_cmd(CMD_INSERT, 126, 8'h5a);
    wait_drained();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_cmd(CMD_GET, $urandom_range(1, 127), 0);
    join
    send_cmd(CMD_CLEAR, 0, 0);

    // Random mix, mostly small lists with narrow value range for matches
    for (int i = 0; i < 1150; i++) begin
      c = $urandom_range(0, 99);
      v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
      r = (list_len > 0) ? $urandom_range(1, list_len + 1) : 1;
      if ($urandom_range(0, 9) == 0) r = $urandom_range(0, 127);
      if (c < 30 && list_len < 40) send_cmd(CMD_INSERT, r, v);
      else if (c < 42) send_cmd(CMD_DELETE, r, v);
      else if (c < 52) send_cmd(CMD_GET, r, v);
      else if (c < 62) send_cmd(CMD_LOCATE, r, v);
      else if (c < 72) send_cmd(CMD_PRIOR, r, v);
      else if (c < 82) send_cmd(CMD_NEXT, r, v);
      else if (c < 98) send_cmd(CMD_TOGGLE, r, v);
      else send_cmd(CMD_CLEAR, r, v);
      if (i == 600) wait_drained();
    end

    wait_drained();
    repeat (300) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
